// ----- hdl/dual_wheel_period_tachometer_macros.svh -----
// assertion macros for the dual wheel period tachometer
`ifndef DUAL_WHEEL_PERIOD_TACHOMETER_MACROS_SVH
`define DUAL_WHEEL_PERIOD_TACHOMETER_MACROS_SVH
`ifndef SYNTH
`define DWPT_ASSERT_HOLD(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("dwpt: invariant violated");
`define DWPT_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("dwpt: sequence violated");
`else
`define DWPT_ASSERT_HOLD(lbl, cond)
`define DWPT_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ----- hdl/dwpt_pkg.sv -----
// shared types and constants of the dual wheel period tachometer
package dwpt_pkg;

    localparam int CAP_IN_W   = 32;
    localparam int PPR_W      = 8;
    localparam int DIA_W      = 12;
    localparam int CLK_W      = 28;
    localparam int TMO_W      = 16;
    localparam int CFG_DATA_W = 28;
    localparam int CFG_IDX_W  = 2;
    localparam int RPM_W      = 24;
    localparam int SPEED_W    = 18;

    localparam logic [CFG_IDX_W-1:0] REG_PPR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIA = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLK = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TMO = 2'd3;

    localparam logic [PPR_W-1:0] PPR_RESET = 8'd1;
    localparam logic [DIA_W-1:0] DIA_RESET = 12'd500;
    localparam logic [CLK_W-1:0] CLK_RESET = 28'd84000000;
    localparam logic [TMO_W-1:0] TMO_RESET = 16'd2000;

    localparam logic KIND_CAPTURE = 1'b0;
    localparam logic KIND_TICK    = 1'b1;

    // clock * 60 width
    localparam int CLK60_W = CLK_W + 6;
    localparam logic [CLK60_W-1:0] SEC_PER_MIN = 34'd60;

    // km/h per rpm in Q40: floor(d * pi_q28 * 60 * 2^12 / 1e6)
    localparam int F_Q       = 40;
    localparam logic [31:0] PI_Q28 = 32'h3243F6A8;
    localparam int F_NUM_W   = 60;
    localparam int F_W       = 40;
    localparam int F_DEN_W   = 20;
    localparam logic [47:0] SPEED_K = 48'(PI_Q28) * 48'd60 * 48'd4096;
    localparam logic [F_DEN_W-1:0] MM_PER_KM_SCALE = 20'd1000000;

    localparam int CNT_W = $clog2(F_NUM_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_DIV,
        S_MUL,
        S_DONE,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_div_ctrl;

endpackage

// ----- hdl/dwpt_serial_div.sv -----
// bit-serial restoring divider, one quotient bit per step
module dwpt_serial_div #(
    parameter int NUM_W = 42,
    parameter int DEN_W = 40
) (
    input  logic                i_clk,
    input  dwpt_pkg::t_div_ctrl i_ctrl,
    input  logic [NUM_W-1:0]    i_num,
    input  logic [DEN_W-1:0]    i_den,
    output logic [NUM_W-1:0]    o_quo
);

    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W:0]   diff;
    logic [DEN_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_quo[NUM_W-1]};
        ge    = trial >= {1'b0, r_den};
        diff  = trial - {1'b0, r_den};
        n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (i_ctrl.step) begin
            r_quo <= {r_quo[NUM_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_quo = r_quo;

endmodule

// ----- hdl/dual_wheel_period_tachometer.sv -----
// top level of the dual wheel period tachometer
//
// Input channel (i_valid, o_stall): a word is either a timer capture of one
// wheel (i_kind = 0, i_wheel, i_capture_value) or a one millisecond tick
// (i_kind = 1). Output channel (o_valid, i_stall): every input word gives
// exactly one output word with rpm and km/h of both wheels.
// Ticks, first captures, zero periods and captures with zero pulses per
// revolution go straight to the push state. A capture that is measured runs
// a bit-serial restoring divider (the km/h factor division by 1e6 sets the
// length of this phase, rpm is divided in the same window) and then a
// bit-serial multiplier before it goes to the push state.
// One word is processed at a time; o_stall is high while it is worked on.
// The output register holds a finished word while i_stall is high, and the
// next input word is taken meanwhile; its result waits until the register
// is free. Reset (i_rst_n low, synchronous) clears both wheels and loads
// the register defaults. Configuration writes (i_cfg_we, i_cfg_idx,
// i_cfg_data) take effect at once; the user makes them only while the block
// is idle, the block itself does not enforce this.
`include "dual_wheel_period_tachometer_macros.svh"

module dual_wheel_period_tachometer #(
    parameter int CAPTURE_WIDTH   = 32,
    parameter int RPM_FRAC_BITS   = 8,
    parameter int SPEED_FRAC_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dwpt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [dwpt_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_kind,
    input  logic                                i_wheel,
    input  logic [dwpt_pkg::CAP_IN_W-1:0]       i_capture_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [dwpt_pkg::RPM_W-1:0]          o_rpm_right,
    output logic [dwpt_pkg::RPM_W-1:0]          o_rpm_left,
    output logic [dwpt_pkg::SPEED_W-1:0]        o_speed_right,
    output logic [dwpt_pkg::SPEED_W-1:0]        o_speed_left
);

    localparam int NUM_W = dwpt_pkg::CLK60_W + RPM_FRAC_BITS;
    localparam int DEN_W = dwpt_pkg::PPR_W + CAPTURE_WIDTH;
    localparam int PROD_W = dwpt_pkg::F_W + NUM_W;
    localparam int SH = dwpt_pkg::F_Q + RPM_FRAC_BITS - SPEED_FRAC_BITS;
    localparam int CW = dwpt_pkg::CNT_W;

    // configuration
    logic [dwpt_pkg::PPR_W-1:0] r_ppr;
    logic [dwpt_pkg::DIA_W-1:0] r_dia;
    logic [dwpt_pkg::CLK_W-1:0] r_clk_hz;
    logic [dwpt_pkg::TMO_W-1:0] r_tmo;

    // wheel state
    logic [CAPTURE_WIDTH-1:0]    r_last   [2];
    logic [1:0]                  r_armed;
    logic [dwpt_pkg::TMO_W-1:0]  r_ms     [2];
    logic [dwpt_pkg::RPM_W-1:0]  r_rpm    [2];
    logic [dwpt_pkg::SPEED_W-1:0] r_speed [2];

    dwpt_pkg::t_state r_state;
    dwpt_pkg::t_state n_state;

    logic                      r_w;
    logic [CAPTURE_WIDTH-1:0]  r_period;
    logic [CW-1:0]             r_cnt;
    logic [dwpt_pkg::RPM_W-1:0] r_rpm_sat;
    logic [dwpt_pkg::F_W-1:0]  r_acc;
    logic [NUM_W-1:0]          r_mlo;

    logic                        r_out_valid;
    logic [dwpt_pkg::RPM_W-1:0]   r_out_rpm_r;
    logic [dwpt_pkg::RPM_W-1:0]   r_out_rpm_l;
    logic [dwpt_pkg::SPEED_W-1:0] r_out_speed_r;
    logic [dwpt_pkg::SPEED_W-1:0] r_out_speed_l;

    logic                      in_acc;
    logic                      out_free;
    logic [CAPTURE_WIDTH-1:0]  cap;
    logic [CAPTURE_WIDTH-1:0]  period;
    logic                      measure;
    logic [dwpt_pkg::TMO_W-1:0] ms_inc [2];

    dwpt_pkg::t_div_ctrl       rpm_ctrl;
    dwpt_pkg::t_div_ctrl       f_ctrl;
    logic [NUM_W-1:0]          rpm_num;
    logic [DEN_W-1:0]          rpm_den;
    logic [NUM_W-1:0]          rpm_quo;
    logic [dwpt_pkg::F_NUM_W-1:0] f_num;
    logic [dwpt_pkg::F_NUM_W-1:0] f_quo;
    logic [dwpt_pkg::F_W-1:0]  f_val;

    logic [dwpt_pkg::F_W:0]    msum;
    logic [PROD_W-1:0]         prod;
    logic                      speed_over;
    logic [dwpt_pkg::SPEED_W-1:0] speed_sat;
    logic                      rpm_over;

    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign cap      = i_capture_value[CAPTURE_WIDTH-1:0];
    assign period   = cap - r_last[i_wheel];
    assign measure  = r_armed[i_wheel] && (period != '0);

    always_comb begin
        for (int w = 0; w < 2; w++) begin
            ms_inc[w] = (r_ms[w] == '1) ? r_ms[w] : r_ms[w] + 1'b1;
        end
    end

    assign rpm_num = NUM_W'(dwpt_pkg::CLK60_W'(r_clk_hz) * dwpt_pkg::SEC_PER_MIN)
                     << RPM_FRAC_BITS;
    assign rpm_den = DEN_W'(r_ppr) * DEN_W'(r_period);
    assign f_num   = dwpt_pkg::F_NUM_W'(r_dia) * dwpt_pkg::F_NUM_W'(dwpt_pkg::SPEED_K);
    assign f_val   = f_quo[dwpt_pkg::F_W-1:0];

    always_comb begin
        rpm_ctrl.load = (r_state == dwpt_pkg::S_SETUP);
        rpm_ctrl.step = (r_state == dwpt_pkg::S_DIV) && (r_cnt < CW'(NUM_W));
        f_ctrl.load   = (r_state == dwpt_pkg::S_SETUP);
        f_ctrl.step   = (r_state == dwpt_pkg::S_DIV);
    end

    dwpt_serial_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_rpm_div (
        .i_clk  (i_clk),
        .i_ctrl (rpm_ctrl),
        .i_num  (rpm_num),
        .i_den  (rpm_den),
        .o_quo  (rpm_quo)
    );

    dwpt_serial_div #(
        .NUM_W (dwpt_pkg::F_NUM_W),
        .DEN_W (dwpt_pkg::F_DEN_W)
    ) u_f_div (
        .i_clk  (i_clk),
        .i_ctrl (f_ctrl),
        .i_num  (f_num),
        .i_den  (dwpt_pkg::MM_PER_KM_SCALE),
        .o_quo  (f_quo)
    );

    always_comb begin
        msum       = {1'b0, r_acc} + (r_mlo[0] ? {1'b0, f_val} : '0);
        prod       = {r_acc, r_mlo};
        speed_over = |prod[PROD_W-1:SH+dwpt_pkg::SPEED_W];
        speed_sat  = speed_over ? '1 : prod[SH +: dwpt_pkg::SPEED_W];
        rpm_over   = |rpm_quo[NUM_W-1:dwpt_pkg::RPM_W];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dwpt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_stall = 1'b1;
        unique case (r_state)
            dwpt_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    if (i_kind == dwpt_pkg::KIND_CAPTURE && measure && r_ppr != '0) begin
                        n_state = dwpt_pkg::S_SETUP;
                    end else begin
                        n_state = dwpt_pkg::S_PUSH;
                    end
                end
            end
            dwpt_pkg::S_SETUP: begin
                n_state = dwpt_pkg::S_DIV;
            end
            dwpt_pkg::S_DIV: begin
                if (r_cnt == CW'(dwpt_pkg::F_NUM_W - 1)) begin
                    n_state = dwpt_pkg::S_MUL;
                end
            end
            dwpt_pkg::S_MUL: begin
                if (r_cnt == CW'(NUM_W - 1)) begin
                    n_state = dwpt_pkg::S_DONE;
                end
            end
            dwpt_pkg::S_DONE: begin
                n_state = dwpt_pkg::S_PUSH;
            end
            dwpt_pkg::S_PUSH: begin
                if (out_free) begin
                    n_state = dwpt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dwpt_pkg::S_IDLE;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppr    <= dwpt_pkg::PPR_RESET;
            r_dia    <= dwpt_pkg::DIA_RESET;
            r_clk_hz <= dwpt_pkg::CLK_RESET;
            r_tmo    <= dwpt_pkg::TMO_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dwpt_pkg::REG_PPR: r_ppr    <= i_cfg_data[dwpt_pkg::PPR_W-1:0];
                dwpt_pkg::REG_DIA: r_dia    <= i_cfg_data[dwpt_pkg::DIA_W-1:0];
                dwpt_pkg::REG_CLK: r_clk_hz <= i_cfg_data[dwpt_pkg::CLK_W-1:0];
                dwpt_pkg::REG_TMO: r_tmo    <= i_cfg_data[dwpt_pkg::TMO_W-1:0];
                default: ;
            endcase
        end
    end

    // wheel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= '0;
            for (int w = 0; w < 2; w++) begin
                r_last[w]  <= '0;
                r_ms[w]    <= '0;
                r_rpm[w]   <= '0;
                r_speed[w] <= '0;
            end
        end else if (in_acc) begin
            if (i_kind == dwpt_pkg::KIND_CAPTURE) begin
                r_last[i_wheel]  <= cap;
                r_armed[i_wheel] <= 1'b1;
                r_ms[i_wheel]    <= '0;
                if (measure && r_ppr == '0) begin
                    r_rpm[i_wheel]   <= '0;
                    r_speed[i_wheel] <= '0;
                end
            end else begin
                for (int w = 0; w < 2; w++) begin
                    r_ms[w] <= ms_inc[w];
                    if (ms_inc[w] > r_tmo) begin
                        r_rpm[w]   <= '0;
                        r_speed[w] <= '0;
                    end
                end
            end
        end else if (r_state == dwpt_pkg::S_DONE) begin
            r_rpm[r_w]   <= r_rpm_sat;
            r_speed[r_w] <= speed_sat;
        end
    end

    // measurement datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_w      <= i_wheel;
            r_period <= period;
        end
        unique case (r_state)
            dwpt_pkg::S_SETUP: begin
                r_cnt <= '0;
            end
            dwpt_pkg::S_DIV: begin
                if (r_cnt == CW'(dwpt_pkg::F_NUM_W - 1)) begin
                    r_cnt     <= '0;
                    r_acc     <= '0;
                    r_mlo     <= rpm_quo;
                    r_rpm_sat <= rpm_over ? '1 : rpm_quo[dwpt_pkg::RPM_W-1:0];
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            dwpt_pkg::S_MUL: begin
                r_cnt <= r_cnt + 1'b1;
                r_acc <= msum[dwpt_pkg::F_W:1];
                r_mlo <= {msum[0], r_mlo[NUM_W-1:1]};
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == dwpt_pkg::S_PUSH && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == dwpt_pkg::S_PUSH && out_free) begin
            r_out_rpm_r   <= r_rpm[0];
            r_out_rpm_l   <= r_rpm[1];
            r_out_speed_r <= r_speed[0];
            r_out_speed_l <= r_speed[1];
        end
    end

    assign o_valid       = r_out_valid;
    assign o_rpm_right   = r_out_rpm_r;
    assign o_rpm_left    = r_out_rpm_l;
    assign o_speed_right = r_out_speed_r;
    assign o_speed_left  = r_out_speed_l;

    `DWPT_ASSERT_NEXT(a_busy_after_accept, in_acc, o_stall)
    `DWPT_ASSERT_NEXT(a_push_loads, r_state == dwpt_pkg::S_PUSH && out_free, o_valid && r_state == dwpt_pkg::S_IDLE)
    `DWPT_ASSERT_NEXT(a_capture_arms, in_acc && i_kind == dwpt_pkg::KIND_CAPTURE, r_armed[$past(i_wheel)])
    `DWPT_ASSERT_HOLD(a_stall_when_busy, r_state == dwpt_pkg::S_IDLE || o_stall)

endmodule

// ----- sim/dual_wheel_period_tachometer_tb.sv -----
// self-checking testbench of the dual wheel period tachometer with a built-in rpm and speed predictor
module dual_wheel_period_tachometer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RPM_FRAC       = 8;
    localparam int SPEED_FRAC     = 8;
    localparam int CAP_W          = 32;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASES         = 12;
    localparam int PHASE_WORDS    = 150;
    localparam int SETTLE_CYCLES  = 200;

    localparam logic [dwpt_pkg::RPM_W-1:0]   RPM_FULL   = '1;
    localparam logic [dwpt_pkg::SPEED_W-1:0] SPEED_FULL = '1;

    typedef struct packed {
        logic [dwpt_pkg::RPM_W-1:0]   rpm_right;
        logic [dwpt_pkg::RPM_W-1:0]   rpm_left;
        logic [dwpt_pkg::SPEED_W-1:0] speed_right;
        logic [dwpt_pkg::SPEED_W-1:0] speed_left;
    } t_reading;

    logic                            i_clk           = 1'b0;
    logic                            i_rst_n         = 1'b0;
    logic                            i_cfg_we        = 1'b0;
    logic [dwpt_pkg::CFG_IDX_W-1:0]  i_cfg_idx       = dwpt_pkg::REG_PPR;
    logic [dwpt_pkg::CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                            i_valid         = 1'b0;
    logic                            i_kind          = dwpt_pkg::KIND_CAPTURE;
    logic                            i_wheel         = 1'b0;
    logic [dwpt_pkg::CAP_IN_W-1:0]   i_capture_value = '0;
    logic                            i_stall         = 1'b0;
    logic                            o_stall;
    logic                            o_valid;
    logic [dwpt_pkg::RPM_W-1:0]      o_rpm_right;
    logic [dwpt_pkg::RPM_W-1:0]      o_rpm_left;
    logic [dwpt_pkg::SPEED_W-1:0]    o_speed_right;
    logic [dwpt_pkg::SPEED_W-1:0]    o_speed_left;

    // predictor copy of the registers and wheel state
    logic [dwpt_pkg::PPR_W-1:0]   ppr_q = dwpt_pkg::PPR_RESET;
    logic [dwpt_pkg::DIA_W-1:0]   dia_q = dwpt_pkg::DIA_RESET;
    logic [dwpt_pkg::CLK_W-1:0]   clk_q = dwpt_pkg::CLK_RESET;
    logic [dwpt_pkg::TMO_W-1:0]   tmo_q = dwpt_pkg::TMO_RESET;
    logic [CAP_W-1:0]             last_cap  [2] = '{'0, '0};
    logic                         armed     [2] = '{1'b0, 1'b0};
    logic [15:0]                  ms_since  [2] = '{'0, '0};
    logic [dwpt_pkg::RPM_W-1:0]   rpm_held  [2] = '{'0, '0};
    logic [dwpt_pkg::SPEED_W-1:0] spd_held  [2] = '{'0, '0};

    t_reading           readings_due [$];
    t_reading           got_rd;
    t_reading           want_rd;
    logic [CAP_W-1:0]   wheel_count [2] = '{32'h0000_0000, 32'hFFFF_FFFF};
    int                 errors      = 0;
    int                 words_sent  = 0;
    int                 quiet_cycles = 0;
    logic               quiet       = 1'b0;
    int                 hold_reqs   = 0;
    int                 hold_seen   = 0;
    int                 hold_left   = 0;

    dual_wheel_period_tachometer #(
        .CAPTURE_WIDTH   (CAP_W),
        .RPM_FRAC_BITS   (RPM_FRAC),
        .SPEED_FRAC_BITS (SPEED_FRAC)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_kind          (i_kind),
        .i_wheel         (i_wheel),
        .i_capture_value (i_capture_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_rpm_right     (o_rpm_right),
        .o_rpm_left      (o_rpm_left),
        .o_speed_right   (o_speed_right),
        .o_speed_left    (o_speed_left)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void measure_wheel(input int w, input logic [CAP_W-1:0] period);
        logic [63:0]  num;
        logic [63:0]  den;
        logic [63:0]  rpm_raw;
        logic [63:0]  kmh_per_rpm;
        logic [127:0] speed_full;
        if (ppr_q == '0) begin
            rpm_held[w] = '0;
            spd_held[w] = '0;
            return;
        end
        num         = (64'(clk_q) * 64'd60) << RPM_FRAC;
        den         = 64'(ppr_q) * 64'(period);
        rpm_raw     = num / den;
        rpm_held[w] = (rpm_raw > 64'(RPM_FULL)) ? RPM_FULL : rpm_raw[dwpt_pkg::RPM_W-1:0];
        kmh_per_rpm = ((64'(dia_q) * 64'(dwpt_pkg::PI_Q28) * 64'd60) << 12) / 64'd1000000;
        speed_full  = (128'(rpm_raw) * 128'(kmh_per_rpm)) >> (40 + RPM_FRAC - SPEED_FRAC);
        spd_held[w] = (speed_full > 128'(SPEED_FULL)) ? SPEED_FULL
                                                       : speed_full[dwpt_pkg::SPEED_W-1:0];
    endfunction

    function automatic void tach_predict(input logic kind, input logic wheel,
                                         input logic [dwpt_pkg::CAP_IN_W-1:0] cap);
        logic [CAP_W-1:0] period;
        int               w;
        if (kind == dwpt_pkg::KIND_CAPTURE) begin
            w      = int'(wheel);
            period = cap[CAP_W-1:0] - last_cap[w];
            if (armed[w] && period != '0) begin
                measure_wheel(w, period);
            end
            last_cap[w] = cap[CAP_W-1:0];
            armed[w]    = 1'b1;
            ms_since[w] = '0;
        end else begin
            for (w = 0; w < 2; w++) begin
                if (ms_since[w] != 16'hFFFF) begin
                    ms_since[w] = ms_since[w] + 16'd1;
                end
                if (ms_since[w] > tmo_q) begin
                    rpm_held[w] = '0;
                    spd_held[w] = '0;
                end
            end
        end
        readings_due.push_back('{rpm_held[0], rpm_held[1], spd_held[0], spd_held[1]});
    endfunction

    function automatic void flag_mismatch(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        errors++;
        if (errors <= 10) begin
            $display("mismatch on %s: expected %0d, got %0d", field, want, got);
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got_rd = '{o_rpm_right, o_rpm_left, o_speed_right, o_speed_left};
            if (readings_due.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected output word: rpm %0d/%0d speed %0d/%0d",
                             got_rd.rpm_right, got_rd.rpm_left,
                             got_rd.speed_right, got_rd.speed_left);
                end
            end else begin
                want_rd = readings_due.pop_front();
                if (got_rd.rpm_right !== want_rd.rpm_right) begin
                    flag_mismatch("rpm_right", want_rd.rpm_right, got_rd.rpm_right);
                end
                if (got_rd.rpm_left !== want_rd.rpm_left) begin
                    flag_mismatch("rpm_left", want_rd.rpm_left, got_rd.rpm_left);
                end
                if (got_rd.speed_right !== want_rd.speed_right) begin
                    flag_mismatch("speed_right", want_rd.speed_right, got_rd.speed_right);
                end
                if (got_rd.speed_left !== want_rd.speed_left) begin
                    flag_mismatch("speed_left", want_rd.speed_left, got_rd.speed_left);
                end
            end
        end
    end

    // receiver: random stalls plus an occasional long hold
    always @(posedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= !quiet && ($urandom_range(0, 99) < 17);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_word(input logic kind, input logic wheel,
                             input logic [dwpt_pkg::CAP_IN_W-1:0] cap);
        if (!quiet && $urandom_range(0, 99) < 17) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_kind          <= kind;
        i_wheel         <= wheel;
        i_capture_value <= cap;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tach_predict(kind, wheel, cap);
        words_sent++;
    endtask

    task automatic capture_after(input int w, input logic [CAP_W-1:0] period);
        wheel_count[w] = wheel_count[w] + period;
        send_word(dwpt_pkg::KIND_CAPTURE, w[0], wheel_count[w]);
    endtask

    task automatic ms_tick();
        send_word(dwpt_pkg::KIND_TICK, 1'($urandom_range(0, 1)), $urandom);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (readings_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [dwpt_pkg::PPR_W-1:0] ppr,
                              input logic [dwpt_pkg::DIA_W-1:0] dia,
                              input logic [dwpt_pkg::CLK_W-1:0] clk_hz,
                              input logic [dwpt_pkg::TMO_W-1:0] tmo);
        logic [dwpt_pkg::CFG_IDX_W-1:0]  idx  [4];
        logic [dwpt_pkg::CFG_DATA_W-1:0] data [4];
        int                              i;
        idx[0]  = dwpt_pkg::REG_PPR;
        idx[1]  = dwpt_pkg::REG_DIA;
        idx[2]  = dwpt_pkg::REG_CLK;
        idx[3]  = dwpt_pkg::REG_TMO;
        data[0] = dwpt_pkg::CFG_DATA_W'(ppr);
        data[1] = dwpt_pkg::CFG_DATA_W'(dia);
        data[2] = dwpt_pkg::CFG_DATA_W'(clk_hz);
        data[3] = dwpt_pkg::CFG_DATA_W'(tmo);
        for (i = 0; i < 4; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx[i];
            i_cfg_data <= data[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        ppr_q = ppr;
        dia_q = dia;
        clk_q = clk_hz;
        tmo_q = tmo;
    endtask

    // arming, zero period, counter wrap, shortest and longest period, ignored tick fields
    task automatic test_first_captures();
        capture_after(0, 32'd0);
        capture_after(1, 32'd0);
        capture_after(0, 32'd84000);
        capture_after(0, 32'd0);
        capture_after(1, 32'h0000_1001);
        capture_after(1, 32'd1);
        capture_after(0, 32'hFFFF_FFFF);
        send_word(dwpt_pkg::KIND_TICK, 1'b1, 32'hFFFF_FFFF);
        send_word(dwpt_pkg::KIND_TICK, 1'b0, 32'h0000_0000);
        drain();
    endtask

    // zero pulses per rev, zero clock, zero diameter and the top of every register
    task automatic test_register_extremes();
        set_config(8'd0, 12'd500, dwpt_pkg::CLK_RESET, dwpt_pkg::TMO_RESET);
        capture_after(0, 32'd1000);
        drain();
        set_config(8'd255, 12'd4095, 28'hFFF_FFFF, 16'd65535);
        capture_after(0, 32'd1);
        capture_after(1, 32'd50000);
        drain();
        set_config(8'd1, 12'd0, 28'd0, 16'd0);
        capture_after(1, 32'd777);
        ms_tick();
        drain();
        set_config(8'd8, 12'd4095, 28'd200000000, dwpt_pkg::TMO_RESET);
        capture_after(0, 32'd123456);
        drain();
    endtask

    task automatic test_stop_timeout();
        set_config(8'd4, 12'd650, dwpt_pkg::CLK_RESET, 16'd3);
        capture_after(0, 32'd2000000);
        capture_after(1, 32'd3000000);
        repeat (4) ms_tick();
        capture_after(0, 32'd2000000);
        ms_tick();
        drain();
    endtask

    // output held off while the sender keeps offering measured captures
    task automatic test_output_backpressure();
        int i;
        set_config(dwpt_pkg::PPR_RESET, dwpt_pkg::DIA_RESET, dwpt_pkg::CLK_RESET,
                   dwpt_pkg::TMO_RESET);
        quiet = 1'b1;
        hold_reqs++;
        for (i = 0; i < 8; i++) begin
            capture_after(i % 2, 32'($urandom_range(5000, 900000)));
        end
        quiet = 1'b0;
        drain();
    endtask

    task automatic test_random_phases();
        int                         phase;
        int                         start;
        int                         pick;
        int                         w;
        logic [dwpt_pkg::PPR_W-1:0] ppr;
        logic [dwpt_pkg::DIA_W-1:0] dia;
        logic [dwpt_pkg::CLK_W-1:0] clk_hz;
        logic [dwpt_pkg::TMO_W-1:0] tmo;
        for (phase = 0; phase < PHASES; phase++) begin
            case ($urandom_range(0, 11))
                0:       ppr = 8'd0;
                1:       ppr = 8'd1;
                2:       ppr = 8'd255;
                default: ppr = dwpt_pkg::PPR_W'($urandom_range(1, 255));
            endcase
            case ($urandom_range(0, 5))
                0:       dia = 12'd0;
                1:       dia = 12'd4095;
                default: dia = dwpt_pkg::DIA_W'($urandom_range(0, 4095));
            endcase
            case ($urandom_range(0, 7))
                0:       clk_hz = 28'd1;
                1:       clk_hz = 28'd200000000;
                2:       clk_hz = 28'hFFF_FFFF;
                default: clk_hz = dwpt_pkg::CLK_W'($urandom_range(1000000, 200000000));
            endcase
            case ($urandom_range(0, 5))
                0:       tmo = 16'd0;
                1:       tmo = dwpt_pkg::TMO_W'($urandom_range(1, 30));
                2:       tmo = 16'd65535;
                3:       tmo = dwpt_pkg::TMO_RESET;
                default: tmo = dwpt_pkg::TMO_W'($urandom_range(0, 65535));
            endcase
            set_config(ppr, dia, clk_hz, tmo);
            quiet = (phase == 4);
            start = words_sent;
            while (words_sent - start < PHASE_WORDS) begin
                w    = $urandom_range(0, 1);
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    capture_after(w, 32'($urandom_range(1000, 5000000)));
                end else if (pick < 62) begin
                    capture_after(w, 32'($urandom_range(1, 255)));
                end else if (pick < 65) begin
                    capture_after(w, 32'd0);
                end else if (pick < 90) begin
                    repeat ($urandom_range(1, 6)) ms_tick();
                end else begin
                    // jump to an unrelated count
                    capture_after(w, $urandom);
                end
            end
            quiet = 1'b0;
            drain();
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_first_captures();
        test_register_extremes();
        test_stop_timeout();
        test_output_backpressure();
        test_random_phases();
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (readings_due.size() != 0) begin
            errors += readings_due.size();
            $display("%0d output words never arrived", readings_due.size());
        end
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/dwpt_pkg.sv
hdl/dwpt_serial_div.sv
hdl/dual_wheel_period_tachometer.sv
sim/dual_wheel_period_tachometer_tb.sv
